// ----- design/adcwg_pkg.sv -----
`default_nettype none

package adcwg_pkg;

	// Generator mode codes held in the configuration register.
	localparam logic [2:0] MODE_PWM    = 3'd5;
	localparam logic [2:0] MODE_BYPASS = 3'd6;

	// Sequence slots: which conversion channel an item belongs to.
	typedef enum logic [1:0] {
		SLOT_FREQ = 2'd0,
		SLOT_AMP  = 2'd1,
		SLOT_SIG  = 2'd2
	} slot_t;

	// One classified beat, handed from the front end to the back end.
	typedef struct packed {
		logic [11:0] sample;
		logic [9:0]  base_period;
		logic [4:0]  gain;
		logic [2:0]  level;
	} entry_t;

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [1:0]  next_channel;
		logic        timer_update;
		logic        timer_run;
		logic        overflow_irq;
		logic [15:0] period;
		logic        duty_valid;
		logic [15:0] duty;
		logic        dac_valid;
		logic [11:0] dac_value;
		logic        led_high;
		logic        led_low;
	} result_t;

endpackage

`default_nettype wire

// ----- design/adc_sequenced_wavegen_control_top.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    sample
// out      output     out_valid/out_ready  next_channel .. led_low (11 fields)
// cfg      input      cfg_valid/cfg_ready  cfg_data (wave_mode)
//
// A sample beat passes through stage one, stage two and the queue before it reaches the output register.
// The block sustains one beat per cycle while the output is not stalled; the
// sequencer update in the back end sets that figure.
// Reset is asynchronous and active low; it clears the sequence, flags and queue.
// A stalled output holds its beat; the front end keeps filling the queue and
// stalls the input only when the queue and both front stages are full.
`default_nettype none

module adc_sequenced_wavegen_control_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       next_channel,
	output logic             timer_update,
	output logic             timer_run,
	output logic             overflow_irq,
	output logic [15:0]      period,
	output logic             duty_valid,
	output logic [15:0]      duty,
	output logic             dac_valid,
	output logic [11:0]      dac_value,
	output logic             led_high,
	output logic             led_low,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data
);

	logic [2:0] wave_mode_q;
	logic       push_valid;
	logic       push_ready;
	logic       pop_valid;
	logic       pop_ready;
	adcwg_pkg::entry_t  push_data;
	adcwg_pkg::entry_t  pop_data;
	adcwg_pkg::result_t result;

	// Mode register; a write takes effect at the next frequency slot.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q <= '0;
		end else if (cfg_valid) begin
			wave_mode_q <= cfg_data;
		end
	end

	adcwg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	adcwg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	adcwg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wave_mode (wave_mode_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	// Result beat onto the output ports.
	assign next_channel = result.next_channel;
	assign timer_update = result.timer_update;
	assign timer_run    = result.timer_run;
	assign overflow_irq = result.overflow_irq;
	assign period       = result.period;
	assign duty_valid   = result.duty_valid;
	assign duty         = result.duty;
	assign dac_valid    = result.dac_valid;
	assign dac_value    = result.dac_value;
	assign led_high     = result.led_high;
	assign led_low      = result.led_low;

endmodule

`default_nettype wire

// ----- design/adcwg_front.sv -----
`default_nettype none

module adcwg_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [11:0]       sample,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output adcwg_pkg::entry_t      push_data
);

	// Period scaling: P = 185 * v / 1000 + 40, the division done by reciprocal.
	localparam logic [19:0] FREQ_MUL   = 20'd185;
	localparam logic [40:0] RECIP_1000 = 41'd1073742;
	localparam logic [9:0]  PERIOD_OFS = 10'd40;
	localparam logic [11:0] FULL_SCALE = 12'd4095;

	// Amplitude level steps of 819 counts.
	localparam logic [11:0] LVL_1 = 12'd819;
	localparam logic [11:0] LVL_2 = 12'd1638;
	localparam logic [11:0] LVL_3 = 12'd2457;
	localparam logic [11:0] LVL_4 = 12'd3276;

	// Gain band lower edges; each edge belongs to the band above it.
	localparam logic [11:0] BAND_G1 = 12'd2095;
	localparam logic [11:0] BAND_G2 = 12'd2000;
	localparam logic [11:0] BAND_G4 = 12'd1800;

	function automatic logic [4:0] pick_gain(input logic [11:0] v);
		logic [4:0] g;
		if (v >= BAND_G1) begin
			g = 5'd1;
		end else if (v >= BAND_G2) begin
			g = 5'd2;
		end else if (v >= BAND_G4) begin
			g = 5'd4;
		end else if (v >= 12'd1600) begin
			g = 5'd6;
		end else if (v >= 12'd1400) begin
			g = 5'd8;
		end else if (v >= 12'd1200) begin
			g = 5'd10;
		end else if (v >= 12'd1000) begin
			g = 5'd12;
		end else if (v >= 12'd800) begin
			g = 5'd14;
		end else if (v >= 12'd600) begin
			g = 5'd16;
		end else if (v >= 12'd400) begin
			g = 5'd18;
		end else begin
			g = 5'd20;
		end
		return g;
	endfunction

	function automatic logic [2:0] pick_level(input logic [11:0] v);
		logic [11:0] y;
		logic [2:0]  l;
		y = FULL_SCALE - v;
		if (y == FULL_SCALE) begin
			l = 3'd5;
		end else if (y >= LVL_4) begin
			l = 3'd4;
		end else if (y >= LVL_3) begin
			l = 3'd3;
		end else if (y >= LVL_2) begin
			l = 3'd2;
		end else if (y >= LVL_1) begin
			l = 3'd1;
		end else begin
			l = 3'd0;
		end
		return l;
	endfunction

	logic        valid_s1;
	logic        valid_s2;
	logic        adv_s2;
	logic [11:0] sample_s1;
	logic [19:0] prod_s1;
	logic [4:0]  gain_s1;
	logic [2:0]  level_s1;
	logic [40:0] scaled;
	logic [9:0]  base_period;
	adcwg_pkg::entry_t entry_s2;

	// Stage two drains into the queue; stage one moves on when stage two frees.
	assign adv_s2   = !valid_s2 || push_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Reciprocal multiply gives the exact quotient over the whole input range.
	assign scaled      = {21'd0, prod_s1} * RECIP_1000;
	assign base_period = scaled[39:30] + PERIOD_OFS;

	assign push_valid = valid_s2;
	assign push_data  = entry_s2;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage payloads: scale and classify in stage one, finish the period in stage two.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
			prod_s1   <= {8'd0, sample} * FREQ_MUL;
			gain_s1   <= pick_gain(sample);
			level_s1  <= pick_level(sample);
		end
		if (adv_s2 && valid_s1) begin
			entry_s2.sample      <= sample_s1;
			entry_s2.base_period <= base_period;
			entry_s2.gain        <= gain_s1;
			entry_s2.level       <= level_s1;
		end
	end

endmodule

`default_nettype wire

// ----- design/adcwg_queue.sv -----
`default_nettype none

module adcwg_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire adcwg_pkg::entry_t push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output adcwg_pkg::entry_t      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	adcwg_pkg::entry_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("queue fill count exceeds its depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not follow a lone pop");

endmodule

`default_nettype wire

// ----- design/adcwg_back.sv -----
`default_nettype none

module adcwg_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [2:0]        wave_mode,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire adcwg_pkg::entry_t pop_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output adcwg_pkg::result_t     result
);

	localparam logic [15:0] PWM_MUL   = 16'd50;
	localparam logic [15:0] DAC_SAT   = 16'd4094;
	localparam logic [11:0] DAC_MAX   = 12'd4095;
	localparam logic [4:0]  GAIN_INIT = 5'd2;

	adcwg_pkg::slot_t slot_q;
	adcwg_pkg::slot_t slot_d;
	logic [2:0]  level_q, level_d;
	logic [4:0]  gain_q, gain_d;
	logic        high_q, high_d;
	logic        low_q, low_d;
	logic        timer_q, timer_d;
	logic        irq_q, irq_d;
	logic        out_valid_q;
	logic        pop;
	logic [15:0] base_ext;
	logic [15:0] duty_step;
	logic [15:0] pwm_period;
	logic [15:0] pwm_duty;
	logic [16:0] amp_prod;
	logic [15:0] amp_half;
	adcwg_pkg::result_t res;
	adcwg_pkg::result_t result_q;

	// Take a beat whenever the output register is free or being emptied.
	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Arithmetic used by the slot handlers.
	assign base_ext   = {6'd0, pop_data.base_period};
	assign pwm_period = base_ext * PWM_MUL;
	assign pwm_duty   = base_ext * duty_step;
	assign amp_prod   = {5'd0, pop_data.sample} * {12'd0, gain_q};
	assign amp_half   = amp_prod[16:1];

	// Duty multiple 10 * min(level + 1, 5).
	always_comb begin
		case (level_q)
			3'd0:    duty_step = 16'd10;
			3'd1:    duty_step = 16'd20;
			3'd2:    duty_step = 16'd30;
			3'd3:    duty_step = 16'd40;
			default: duty_step = 16'd50;
		endcase
	end

	// Slot handling: next state and the result beat.
	always_comb begin
		slot_d  = slot_q;
		level_d = level_q;
		gain_d  = gain_q;
		high_d  = high_q;
		low_d   = low_q;
		timer_d = timer_q;
		irq_d   = irq_q;
		res     = '0;
		case (slot_q)
			adcwg_pkg::SLOT_FREQ: begin
				if (wave_mode == adcwg_pkg::MODE_PWM) begin
					res.timer_update = 1'b1;
					res.period       = pwm_period;
					res.duty_valid   = 1'b1;
					res.duty         = pwm_duty;
					timer_d          = 1'b1;
					irq_d            = 1'b0;
					slot_d           = adcwg_pkg::SLOT_AMP;
				end else if (wave_mode == adcwg_pkg::MODE_BYPASS) begin
					timer_d = 1'b0;
					irq_d   = 1'b0;
					gain_d  = pop_data.gain;
					slot_d  = adcwg_pkg::SLOT_SIG;
				end else begin
					res.timer_update = 1'b1;
					res.period       = base_ext;
					timer_d          = 1'b1;
					irq_d            = 1'b1;
					slot_d           = adcwg_pkg::SLOT_AMP;
				end
			end
			adcwg_pkg::SLOT_AMP: begin
				level_d = pop_data.level;
				slot_d  = adcwg_pkg::SLOT_FREQ;
			end
			default: begin
				// Signal slot, and the unused code treated the same way.
				res.dac_valid = 1'b1;
				if (amp_half > DAC_SAT) begin
					res.dac_value = DAC_MAX;
					high_d        = 1'b1;
				end else if (amp_half == '0) begin
					res.dac_value = '0;
					low_d         = 1'b1;
				end else begin
					res.dac_value = amp_half[11:0];
					high_d        = 1'b0;
					low_d         = 1'b0;
				end
				slot_d = adcwg_pkg::SLOT_FREQ;
			end
		endcase
		res.next_channel = slot_d;
		res.timer_run    = timer_d;
		res.overflow_irq = irq_d;
		res.led_high     = high_d;
		res.led_low      = low_d;
	end

	// Sequencer state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= adcwg_pkg::SLOT_FREQ;
			level_q     <= '0;
			gain_q      <= GAIN_INIT;
			high_q      <= 1'b0;
			low_q       <= 1'b0;
			timer_q     <= 1'b0;
			irq_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				slot_q      <= slot_d;
				level_q     <= level_d;
				gain_q      <= gain_d;
				high_q      <= high_d;
				low_q       <= low_d;
				timer_q     <= timer_d;
				irq_q       <= irq_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res;
		end
	end

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("a taken beat did not reach the output register");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.timer_update && result_q.dac_valid))
		else $error("timer update and converter sample in one beat");

	a_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.duty_valid |-> result_q.timer_update && !result_q.overflow_irq)
		else $error("duty update without a pwm period update");

	a_bypass_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.dac_valid |-> !result_q.timer_run)
		else $error("converter sample produced with the timer running");

endmodule

`default_nettype wire

// ----- sim/adc_sequenced_wavegen_control_top_tb.sv -----
`default_nettype none

module adc_sequenced_wavegen_control_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 40;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 40;
	localparam int PHASES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [11:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] next_channel;
	logic timer_update;
	logic timer_run;
	logic overflow_irq;
	logic [15:0] period;
	logic duty_valid;
	logic [15:0] duty;
	logic dac_valid;
	logic [11:0] dac_value;
	logic led_high;
	logic led_low;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_data = '0;

	adc_sequenced_wavegen_control_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_channel(next_channel),
		.timer_update(timer_update),
		.timer_run(timer_run),
		.overflow_irq(overflow_irq),
		.period(period),
		.duty_valid(duty_valid),
		.duty(duty),
		.dac_valid(dac_valid),
		.dac_value(dac_value),
		.led_high(led_high),
		.led_low(led_low),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Free-running 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Samples waiting to be offered, and results the sequencer should produce.
	logic [11:0] sample_backlog[$];
	adcwg_pkg::result_t awaited_results[$];

	// Shadow of the sequencer state and the mode register.
	adcwg_pkg::slot_t cur_slot = adcwg_pkg::SLOT_FREQ;
	logic [2:0] cur_mode = '0;
	logic [2:0] lvl_q = '0;
	logic [4:0] gain_q = 5'd2;
	logic hi_q = 1'b0;
	logic lo_q = 1'b0;
	logic run_q = 1'b0;
	logic irq_q = 1'b0;

	bit idle_on = 1'b1;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int in_gap = 0;
	int out_gap = 0;
	int quiet = 0;
	int errors = 0;
	int samples_queued = 0;
	int samples_taken = 0;
	int results_seen = 0;
	int mode_writes = 0;
	int reloads = 0;
	int duty_updates = 0;
	int amp_outputs = 0;
	int clipped_high = 0;
	int clipped_zero = 0;

	// Directed sequences: normal timer, pwm, then bypass amplifier pairs.
	logic [11:0] dir_normal[4] = '{12'd0, 12'd4095, 12'd4095, 12'd0};
	logic [11:0] dir_pwm[6] = '{12'd4095, 12'd819, 12'd1, 12'd4094, 12'd2000, 12'd2048};
	logic [11:0] dir_bypass[16] = '{12'd2095, 12'd4095, 12'd2094, 12'd4094,
		12'd2000, 12'd4095, 12'd400, 12'd0, 12'd1999, 12'd1000,
		12'd399, 12'd4095, 12'd2095, 12'd1, 12'd1600, 12'd2};
	logic [2:0] phase_modes[PHASES] = '{3'd7, adcwg_pkg::MODE_PWM, adcwg_pkg::MODE_BYPASS,
		3'd1, 3'd0, adcwg_pkg::MODE_BYPASS, adcwg_pkg::MODE_PWM, 3'd2, 3'd3,
		adcwg_pkg::MODE_BYPASS, 3'd4, adcwg_pkg::MODE_PWM};

	// Advance the shadow sequencer by one sample and queue the result it implies.
	task automatic sequence_sample(input logic [11:0] v);
		adcwg_pkg::result_t r;
		int unsigned p;
		int unsigned k;
		int unsigned x;
		r = '0;
		case (cur_slot)
			adcwg_pkg::SLOT_FREQ: begin
				p = 185 * int'(v) / 1000 + 40;
				if (cur_mode == adcwg_pkg::MODE_PWM) begin
					// Levels above four are capped at a full 50P duty.
					k = (lvl_q >= 3'd4) ? 5 : int'(lvl_q) + 1;
					r.timer_update = 1'b1;
					r.period = 16'(50 * p);
					r.duty_valid = 1'b1;
					r.duty = 16'(10 * p * k);
					run_q = 1'b1;
					irq_q = 1'b0;
					cur_slot = adcwg_pkg::SLOT_AMP;
				end else if (cur_mode == adcwg_pkg::MODE_BYPASS) begin
					// Gain bands; each edge belongs to the band above it.
					if (v >= 12'd2095) gain_q = 5'd1;
					else if (v >= 12'd2000) gain_q = 5'd2;
					else if (v >= 12'd1800) gain_q = 5'd4;
					else if (v < 12'd400) gain_q = 5'd20;
					else gain_q = 5'(6 + 2 * ((1799 - int'(v)) / 200));
					run_q = 1'b0;
					irq_q = 1'b0;
					cur_slot = adcwg_pkg::SLOT_SIG;
				end else begin
					r.timer_update = 1'b1;
					r.period = 16'(p);
					run_q = 1'b1;
					irq_q = 1'b1;
					cur_slot = adcwg_pkg::SLOT_AMP;
				end
			end
			adcwg_pkg::SLOT_AMP: begin
				lvl_q = 3'((4095 - int'(v)) / 819);
				cur_slot = adcwg_pkg::SLOT_FREQ;
			end
			default: begin
				x = int'(v) * int'(gain_q) / 2;
				r.dac_valid = 1'b1;
				if (x > 4094) begin
					r.dac_value = 12'd4095;
					hi_q = 1'b1;
				end else if (x == 0) begin
					r.dac_value = 12'd0;
					lo_q = 1'b1;
				end else begin
					r.dac_value = 12'(x);
					hi_q = 1'b0;
					lo_q = 1'b0;
				end
				cur_slot = adcwg_pkg::SLOT_FREQ;
			end
		endcase
		r.next_channel = cur_slot;
		r.timer_run = run_q;
		r.overflow_irq = irq_q;
		r.led_high = hi_q;
		r.led_low = lo_q;
		reloads += r.timer_update;
		duty_updates += r.duty_valid;
		amp_outputs += r.dac_valid;
		if (r.dac_valid && r.dac_value == 12'd4095) clipped_high++;
		if (r.dac_valid && r.dac_value == 12'd0) clipped_zero++;
		awaited_results.push_back(r);
	endtask

	// One line per mismatch; the count decides the verdict.
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic check_field(input string what, input int unsigned got,
			input int unsigned want);
		if (got != want) report_mismatch(what, got, want);
	endtask

	// Sample sender: pops the backlog, holds each beat until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				sequence_sample(sample);
				samples_taken++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (sample_backlog.size() != 0) begin
					if (idle_on && $urandom_range(0, 5) == 0) begin
						in_gap <= $urandom_range(0, 5);
						in_valid <= 1'b0;
					end else begin
						in_valid <= 1'b1;
						sample <= sample_backlog.pop_front();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-offs, counted here on request from the sequence.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_served <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Result receiver: compares each beat with the oldest awaited result.
	always @(posedge clk or negedge arst_n) begin
		adcwg_pkg::result_t seen;
		adcwg_pkg::result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				seen = '{next_channel, timer_update, timer_run, overflow_irq, period,
					duty_valid, duty, dac_valid, dac_value, led_high, led_low};
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result beat, dac_value", seen.dac_value, 0);
				end else begin
					want = awaited_results.pop_front();
					check_field("next_channel", seen.next_channel, want.next_channel);
					check_field("timer_update", seen.timer_update, want.timer_update);
					check_field("timer_run", seen.timer_run, want.timer_run);
					check_field("overflow_irq", seen.overflow_irq, want.overflow_irq);
					check_field("period", seen.period, want.period);
					check_field("duty_valid", seen.duty_valid, want.duty_valid);
					check_field("duty", seen.duty, want.duty);
					check_field("dac_valid", seen.dac_valid, want.dac_valid);
					check_field("dac_value", seen.dac_value, want.dac_value);
					check_field("led_high", seen.led_high, want.led_high);
					check_field("led_low", seen.led_low, want.led_low);
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_gap <= $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any beat on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet);
			$display("adc_sequenced_wavegen_control_top verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Random sample, weighted toward band edges, level edges and the rails.
	function automatic logic [11:0] pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 4095;
			2: v = 400 + 200 * $urandom_range(0, 7) - $urandom_range(0, 1);
			3: v = ($urandom_range(0, 1) ? 2095 : 2000) - $urandom_range(0, 1);
			4: v = 4095 - 819 * $urandom_range(0, 5);
			5: v = $urandom_range(0, 3);
			default: v = $urandom_range(0, 4095);
		endcase
		if (v < 0) v = 0;
		return 12'(v);
	endfunction

	// Hand one sample to the sender and count it as owed a result.
	task automatic offer_sample(input logic [11:0] v);
		sample_backlog.push_back(v);
		samples_queued++;
	endtask

	// Wait until the sender is empty and every owed result has been taken.
	task automatic wait_drained();
		while (sample_backlog.size() != 0 || in_valid || results_seen < samples_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mode register write; only issued while the block is drained.
	task automatic write_mode(input logic [2:0] m);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cur_mode = m;
		mode_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Test sequence.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(3'd0);
		foreach (dir_normal[i]) offer_sample(dir_normal[i]);
		write_mode(adcwg_pkg::MODE_PWM);
		foreach (dir_pwm[i]) offer_sample(dir_pwm[i]);
		write_mode(adcwg_pkg::MODE_BYPASS);
		foreach (dir_bypass[i]) offer_sample(dir_bypass[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			write_mode(phase_modes[ph]);
			if (ph == PHASES - 1) idle_on = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				offer_sample(pick_sample());
				// Sender pauses halfway until everything has come back.
				if (ph == 4 && n == PHASE_ITEMS / 2) wait_drained();
			end
			// Receiver holds off while the sender keeps offering beats.
			if (ph == 2 || ph == 9) holds_asked++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch("results never delivered", 0, awaited_results.size());

		$display("Ran %0d samples and %0d results across %0d mode writes (modes 0..7).",
			samples_taken, results_seen, mode_writes);
		$display("Saw %0d timer reloads, %0d duty updates, %0d amp outputs (%0d high, %0d zero).",
			reloads, duty_updates, amp_outputs, clipped_high, clipped_zero);
		if (errors == 0) begin
			$display("adc_sequenced_wavegen_control_top verification clean");
		end else begin
			$display("adc_sequenced_wavegen_control_top verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/adcwg_pkg.sv
design/adcwg_front.sv
design/adcwg_queue.sv
design/adcwg_back.sv
design/adc_sequenced_wavegen_control_top.sv
sim/adc_sequenced_wavegen_control_top_tb.sv
